@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file uwjs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ rtl/core/uwjs_pkg.sv @@
`default_nettype none
package uwjs_pkg;

  localparam int CORDIC_STAGES_DEF    = 16;
  localparam int VECTOR_FRAC_BITS_DEF = 15;

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam logic [1:0] REG_ORD  = 2'd0;
  localparam logic [1:0] REG_EXT  = 2'd1;
  localparam logic [1:0] REG_TILT = 2'd2;
  localparam logic [1:0] REG_AZIM = 2'd3;

  localparam logic [13:0] ORD_RESET  = 14'd6144;
  localparam logic [13:0] EXT_RESET  = 14'd6144;
  localparam logic [15:0] TILT_RESET = 16'd0;
  localparam logic [15:0] AZIM_RESET = 16'd0;

  // Cycles from an accepted transaction to the sampled result strobe.
  function automatic int pipe_latency(input int stages);
    return 2 * stages + 89;
  endfunction

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] turn_atan(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/uwjs_cordic.sv @@
`default_nettype none
module uwjs_cordic #(
  parameter int STAGES = uwjs_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic [31:0]        ang,
  output logic signed [31:0] cs,
  output logic signed [31:0] sn
);

  logic [31:0] ang_q;
  logic [31:0] ang_f;
  logic        flip;

  assign ang_q = ang + 32'h4000_0000;
  assign flip  = ang_q[31];
  assign ang_f = flip ? (ang + 32'h8000_0000) : ang;

  logic signed [33:0] x_r [0:STAGES];
  logic signed [33:0] y_r [0:STAGES];
  logic signed [33:0] z_r [0:STAGES];
  logic               flip_r [0:STAGES];
  logic signed [31:0] cs_r;
  logic signed [31:0] sn_r;

  always_ff @(posedge clk) begin
    x_r[0]    <= $signed({2'b00, uwjs_pkg::CORDIC_GAIN_Q30});
    y_r[0]    <= '0;
    z_r[0]    <= $signed({{2{ang_f[31]}}, ang_f});
    flip_r[0] <= flip;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [33:0] ATAN = $signed({2'b00, uwjs_pkg::turn_atan(5'(i))});
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!z_r[i][33]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - ATAN;
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + ATAN;
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  logic signed [33:0] x_o;
  logic signed [33:0] y_o;
  assign x_o = flip_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
  assign y_o = flip_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];

  always_ff @(posedge clk) begin
    cs_r <= x_o[31:0];
    sn_r <= y_o[31:0];
  end

  assign cs = cs_r;
  assign sn = sn_r;

endmodule
`default_nettype wire

@@ rtl/core/uniaxial_waveplate_jones_step.sv @@
// Throughput: one transaction per cycle; busy is always low and out_valid cannot be held off.
// The latency is set by two of the three CORDIC chains, a 30-stage square root, a 28-stage
// index divider and a 15-stage divider by the wavelength, all fully pipelined.
// Synchronous active-low reset loads the register defaults and clears every valid bit.
`default_nettype none
module uniaxial_waveplate_jones_step #(
  parameter int CORDIC_STAGES    = uwjs_pkg::CORDIC_STAGES_DEF,
  parameter int VECTOR_FRAC_BITS = uwjs_pkg::VECTOR_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        in_wavelength_nm,
  input  logic [23:0]        in_slab_thickness_nm,
  input  logic signed [15:0] in_x_real,
  input  logic signed [15:0] in_x_imag,
  input  logic signed [15:0] in_y_real,
  input  logic signed [15:0] in_y_imag,
  output logic               out_valid,
  output logic signed [15:0] out_x_real,
  output logic signed [15:0] out_x_imag,
  output logic signed [15:0] out_y_real,
  output logic signed [15:0] out_y_imag,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CB = (VECTOR_FRAC_BITS < 30) ? VECTOR_FRAC_BITS : 30;
  localparam int SH = 30 - CB;
  localparam int KW = CB + 2;
  localparam int PW = KW + 16;
  localparam int SW = PW + 2;

  localparam int CL     = CORDIC_STAGES + 2;
  localparam int T_TILT = CL - 1;
  localparam int T_SUM  = T_TILT + 4;
  localparam int T_ROOT = T_SUM + 30;
  localparam int T_DV0  = T_ROOT + 1;
  localparam int T_DIV  = T_DV0 + 28;
  localparam int T_E    = T_DIV + 1;
  localparam int T_F    = T_E + 1;
  localparam int T_FRAC = T_F + 15;
  localparam int T_G    = T_FRAC + 1;
  localparam int T_CS   = T_G + CL;
  localparam int T_I    = T_CS + 2;
  localparam int T_J    = T_I + 1;
  localparam int T_OUT  = T_J + 1;
  localparam int SIDE_LEN = T_J;

  typedef struct packed {
    logic [11:0]        lam;
    logic [23:0]        d;
    logic signed [15:0] xr;
    logic signed [15:0] xi;
    logic signed [15:0] yr;
    logic signed [15:0] yi;
  } side_t;

  // Configuration registers.
  logic [13:0] ord_r;
  logic [13:0] ext_r;
  logic [15:0] tilt_r;
  logic [15:0] azim_r;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r  <= uwjs_pkg::ORD_RESET;
      ext_r  <= uwjs_pkg::EXT_RESET;
      tilt_r <= uwjs_pkg::TILT_RESET;
      azim_r <= uwjs_pkg::AZIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        uwjs_pkg::REG_ORD:  ord_r  <= pwdata[13:0];
        uwjs_pkg::REG_EXT:  ext_r  <= pwdata[13:0];
        uwjs_pkg::REG_TILT: tilt_r <= pwdata[15:0];
        uwjs_pkg::REG_AZIM: azim_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      uwjs_pkg::REG_ORD:  prdata = {18'd0, ord_r};
      uwjs_pkg::REG_EXT:  prdata = {18'd0, ext_r};
      uwjs_pkg::REG_TILT: prdata = {16'd0, tilt_r};
      uwjs_pkg::REG_AZIM: prdata = {16'd0, azim_r};
      default:            prdata = '0;
    endcase
  end

  // Transaction fields and valid bits travel alongside the arithmetic.
  side_t side_r  [0:SIDE_LEN-1];
  logic  valid_r [0:T_OUT];

  always_ff @(posedge clk) begin
    side_r[0] <= {in_wavelength_nm, in_slab_thickness_nm,
                  in_x_real, in_x_imag, in_y_real, in_y_imag};
    for (int i = 1; i < SIDE_LEN; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= T_OUT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      valid_r[0] <= start;
      for (int i = 1; i <= T_OUT; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  // Effective extraordinary index.
  logic signed [31:0] tilt_cs;
  logic signed [31:0] tilt_sn;

  uwjs_cordic #(.STAGES(CORDIC_STAGES)) u_tilt (
    .clk (clk),
    .ang ({tilt_r, 16'd0}),
    .cs  (tilt_cs),
    .sn  (tilt_sn)
  );

  logic signed [32:0] ct_rnd;
  logic signed [32:0] st_rnd;
  logic signed [32:0] ct_q;
  logic signed [32:0] st_q;
  logic signed [32:0] cm_w;
  logic signed [32:0] sm_w;

  assign ct_rnd = $signed({tilt_cs[31], tilt_cs}) + 33'sd16384;
  assign st_rnd = $signed({tilt_sn[31], tilt_sn}) + 33'sd16384;
  assign ct_q   = ct_rnd >>> 15;
  assign st_q   = st_rnd >>> 15;
  assign cm_w   = ct_q[32] ? -ct_q : ct_q;
  assign sm_w   = st_q[32] ? -st_q : st_q;

  logic [16:0] cm_r;
  logic [16:0] sm_r;
  logic [30:0] a_r;
  logic [30:0] b_r;
  logic [61:0] aa_r;
  logic [61:0] bb_r;
  logic [27:0] nn_r;
  logic [59:0] sq_v_r   [0:30];
  logic [59:0] sq_res_r [1:30];

  always_ff @(posedge clk) begin
    cm_r      <= cm_w[16:0];
    sm_r      <= sm_w[16:0];
    a_r       <= {14'd0, cm_r} * {17'd0, ext_r};
    b_r       <= {14'd0, sm_r} * {17'd0, ord_r};
    aa_r      <= {31'd0, a_r} * {31'd0, a_r};
    bb_r      <= {31'd0, b_r} * {31'd0, b_r};
    sq_v_r[0] <= aa_r[59:0] + bb_r[59:0];
    nn_r      <= {14'd0, ord_r} * {14'd0, ext_r};
  end

  for (genvar j = 0; j < 30; j++) begin : g_sqrt
    localparam logic [59:0] BIT = 60'd1 << (58 - 2 * j);
    logic [59:0] res_in;
    logic [59:0] trial;
    if (j == 0) begin : g_first
      assign res_in = '0;
    end else begin : g_next
      assign res_in = sq_res_r[j];
    end
    assign trial = res_in + BIT;
    always_ff @(posedge clk) begin
      if (sq_v_r[j] >= trial) begin
        sq_v_r[j+1]   <= sq_v_r[j] - trial;
        sq_res_r[j+1] <= (res_in >> 1) + BIT;
      end else begin
        sq_v_r[j+1]   <= sq_v_r[j];
        sq_res_r[j+1] <= res_in >> 1;
      end
    end
  end

  logic [54:0] dv_rem_r  [0:28];
  logic [29:0] dv_root_r [0:27];
  logic        dv_zero_r [0:28];
  logic [27:0] dv_q_r    [1:28];

  always_ff @(posedge clk) begin
    dv_rem_r[0]  <= {nn_r, 27'd0};
    dv_root_r[0] <= sq_res_r[30][29:0];
    dv_zero_r[0] <= (sq_res_r[30] == 60'd0);
  end

  for (genvar j = 0; j < 28; j++) begin : g_div
    logic [56:0] trial;
    logic [27:0] q_in;
    logic        hit;
    if (j == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = dv_q_r[j];
    end
    assign trial = {27'd0, dv_root_r[j]} << (27 - j);
    assign hit   = ({2'b00, dv_rem_r[j]} >= trial);
    always_ff @(posedge clk) begin
      dv_rem_r[j+1]  <= hit ? (dv_rem_r[j] - trial[54:0]) : dv_rem_r[j];
      dv_q_r[j+1]    <= {q_in[26:0], hit};
      dv_zero_r[j+1] <= dv_zero_r[j];
    end
    if (j < 27) begin : g_root
      always_ff @(posedge clk) begin
        dv_root_r[j+1] <= dv_root_r[j];
      end
    end
  end

  // Retardance in turns.
  logic [13:0]        idx_max;
  logic [27:0]        ne_t;
  logic signed [28:0] delta;
  logic signed [28:0] delta_abs;

  assign idx_max   = (ord_r > ext_r) ? ord_r : ext_r;
  assign ne_t      = dv_zero_r[28] ? {2'b00, idx_max, 12'd0} : dv_q_r[28];
  assign delta     = $signed({1'b0, ne_t}) - $signed({3'b000, ord_r, 12'd0});
  assign delta_abs = delta[28] ? -delta : delta;

  logic [27:0] e_abs_r;
  logic        e_neg_r;
  logic [59:0] ld_num_r [0:14];
  logic [11:0] ld_rem_r [1:15];
  logic [31:0] ld_q_r   [1:15];
  logic        ld_neg_r [0:15];

  always_ff @(posedge clk) begin
    e_abs_r     <= delta_abs[27:0];
    e_neg_r     <= delta[28];
    ld_num_r[0] <= {({24'd0, e_abs_r} * {28'd0, side_r[T_F-1].d}), 8'd0};
    ld_neg_r[0] <= e_neg_r;
  end

  for (genvar j = 0; j < 15; j++) begin : g_lam
    logic [11:0] lam;
    logic [11:0] rem_in;
    logic [31:0] q_in;
    logic [59:0] st_num;
    logic [11:0] st_rem;
    logic [31:0] st_q;
    logic [12:0] st_t;
    assign lam = side_r[T_F+j].lam;
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = ld_rem_r[j];
      assign q_in   = ld_q_r[j];
    end
    always_comb begin
      st_num = ld_num_r[j];
      st_rem = rem_in;
      st_q   = q_in;
      st_t   = '0;
      for (int b = 0; b < 4; b++) begin
        st_t   = {st_rem, st_num[59]};
        st_num = {st_num[58:0], 1'b0};
        if (st_t >= {1'b0, lam}) begin
          st_t = st_t - {1'b0, lam};
          st_q = {st_q[30:0], 1'b1};
        end else begin
          st_q = {st_q[30:0], 1'b0};
        end
        st_rem = st_t[11:0];
      end
    end
    always_ff @(posedge clk) begin
      ld_rem_r[j+1] <= st_rem;
      ld_q_r[j+1]   <= st_q;
      ld_neg_r[j+1] <= ld_neg_r[j];
    end
    if (j < 14) begin : g_num
      always_ff @(posedge clk) begin
        ld_num_r[j+1] <= st_num;
      end
    end
  end

  logic [31:0] frac_r;

  always_ff @(posedge clk) begin
    if (side_r[T_FRAC].lam == 12'd0) begin
      frac_r <= '0;
    end else if (ld_neg_r[15]) begin
      frac_r <= 32'd0 - ld_q_r[15];
    end else begin
      frac_r <= ld_q_r[15];
    end
  end

  // Retarder matrix terms.
  logic signed [31:0] half_cs;
  logic signed [31:0] half_sn;
  logic signed [31:0] azim_cs;
  logic signed [31:0] azim_sn;

  uwjs_cordic #(.STAGES(CORDIC_STAGES)) u_half (
    .clk (clk),
    .ang ({1'b0, frac_r[31:1]}),
    .cs  (half_cs),
    .sn  (half_sn)
  );

  uwjs_cordic #(.STAGES(CORDIC_STAGES)) u_azim (
    .clk (clk),
    .ang ({azim_r[14:0], 17'd0}),
    .cs  (azim_cs),
    .sn  (azim_sn)
  );

  logic signed [33:0] k_t;
  logic signed [33:0] k_sh;

  assign k_t  = $signed({half_cs[31], half_cs, 1'b0}) + (34'sd1 <<< SH);
  assign k_sh = k_t >>> (SH + 1);

  logic signed [KW-1:0] k_r;
  logic signed [63:0]   pf_r;
  logic signed [63:0]   qf_r;

  always_ff @(posedge clk) begin
    k_r  <= k_sh[KW-1:0];
    pf_r <= 64'(half_sn) * 64'(azim_cs);
    qf_r <= 64'(half_sn) * 64'(azim_sn);
  end

  logic signed [35:0] p_t;
  logic signed [35:0] q_t;
  logic signed [35:0] p_sh;
  logic signed [35:0] q_sh;

  assign p_t  = $signed({pf_r[63], pf_r[63:30], 1'b0}) + (36'sd1 <<< SH);
  assign q_t  = $signed({qf_r[63], qf_r[63:30], 1'b0}) + (36'sd1 <<< SH);
  assign p_sh = p_t >>> (SH + 1);
  assign q_sh = q_t >>> (SH + 1);

  logic signed [KW-1:0] coef_r [0:2];

  always_ff @(posedge clk) begin
    coef_r[0] <= k_r;
    coef_r[1] <= p_sh[KW-1:0];
    coef_r[2] <= q_sh[KW-1:0];
  end

  // Matrix times vector.
  logic signed [15:0]   vec_w  [0:3];
  logic signed [PW-1:0] prod_r [0:11];

  assign vec_w[0] = side_r[T_I].xr;
  assign vec_w[1] = side_r[T_I].xi;
  assign vec_w[2] = side_r[T_I].yr;
  assign vec_w[3] = side_r[T_I].yi;

  for (genvar c = 0; c < 3; c++) begin : g_coef
    for (genvar v = 0; v < 4; v++) begin : g_vec
      always_ff @(posedge clk) begin
        prod_r[c*4+v] <= PW'(coef_r[c]) * PW'(vec_w[v]);
      end
    end
  end

  logic signed [SW-1:0] sum_w [0:3];

  assign sum_w[0] = SW'(prod_r[0]) + SW'(prod_r[5]) + SW'(prod_r[11]);
  assign sum_w[1] = SW'(prod_r[1]) - SW'(prod_r[4]) - SW'(prod_r[10]);
  assign sum_w[2] = SW'(prod_r[9]) + SW'(prod_r[2]) - SW'(prod_r[7]);
  assign sum_w[3] = SW'(prod_r[3]) + SW'(prod_r[6]) - SW'(prod_r[8]);

  logic signed [15:0] out_r [0:3];

  for (genvar o = 0; o < 4; o++) begin : g_out
    logic signed [SW-1:0] rnd;
    assign rnd = (sum_w[o] + (SW'(1) <<< (CB - 1))) >>> CB;
    always_ff @(posedge clk) begin
      if (rnd > SW'(32767)) begin
        out_r[o] <= 16'sh7FFF;
      end else if (rnd < -SW'(32768)) begin
        out_r[o] <= 16'sh8000;
      end else begin
        out_r[o] <= rnd[15:0];
      end
    end
  end

  assign out_valid  = valid_r[T_OUT];
  assign out_x_real = out_r[0];
  assign out_x_imag = out_r[1];
  assign out_y_real = out_r[2];
  assign out_y_imag = out_r[3];

endmodule
`default_nettype wire

@@ rtl/core/uwjs_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module uwjs_checker #(
  parameter int STAGES = uwjs_pkg::CORDIC_STAGES_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic pready
);

  localparam int LAT = uwjs_pkg::pipe_latency(STAGES);

  `ASSERT_RST(a_result_has_source, clk, rst_n, out_valid |-> $past(start && !busy, LAT))
  `ASSERT_RST(a_transaction_returns, clk, rst_n, (start && !busy) |-> ##LAT out_valid)
  `ASSERT_ANY(a_quiet_after_reset, clk, $rose(rst_n) |-> !out_valid)
  `ASSERT_RST(a_always_ready, clk, rst_n, pready && !busy)

endmodule

bind uniaxial_waveplate_jones_step uwjs_checker #(.STAGES(CORDIC_STAGES)) u_uwjs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .pready    (pready)
);
`default_nettype wire

@@ sim/tb_uniaxial_waveplate_jones_step.sv @@
`timescale 1ns / 1ps
module tb_uniaxial_waveplate_jones_step;

  localparam int STAGES  = uwjs_pkg::CORDIC_STAGES_DEF;
  localparam int COEF    = (uwjs_pkg::VECTOR_FRAC_BITS_DEF < 30) ?
                           uwjs_pkg::VECTOR_FRAC_BITS_DEF : 30;
  localparam int LATENCY = 2 * uwjs_pkg::CORDIC_STAGES_DEF + 89;

  localparam longint ATAN_TURN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  typedef struct packed {
    logic [11:0]        lam;
    logic [23:0]        thick;
    logic signed [15:0] xr, xi, yr, yi;
  } beam_t;

  typedef struct packed {
    logic signed [15:0] xr, xi, yr, yi;
  } jones_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  beam_t cur_beam = '0;
  logic out_valid;
  logic signed [15:0] out_x_real, out_x_imag, out_y_real, out_y_imag;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [13:0] cfg_no = uwjs_pkg::ORD_RESET;
  logic [13:0] cfg_ne = uwjs_pkg::EXT_RESET;
  logic [15:0] cfg_tilt = uwjs_pkg::TILT_RESET;
  logic [15:0] cfg_azim = uwjs_pkg::AZIM_RESET;

  beam_t  pending_beams[$];
  jones_t expected_vectors[$];
  int gap_left = 0;
  bit no_gaps = 0;
  bit failed = 0;

  always #2 clk = ~clk;

  uniaxial_waveplate_jones_step dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_wavelength_nm(cur_beam.lam), .in_slab_thickness_nm(cur_beam.thick),
    .in_x_real(cur_beam.xr), .in_x_imag(cur_beam.xi),
    .in_y_real(cur_beam.yr), .in_y_imag(cur_beam.yi),
    .out_valid(out_valid), .out_x_real(out_x_real), .out_x_imag(out_x_imag),
    .out_y_real(out_y_real), .out_y_imag(out_y_imag),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic longint rnd_shift(longint v, int n);
    if (n <= 0) return v;
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic void rotate(input logic [31:0] ang, output longint cs, output longint sn);
    logic [31:0] t;
    logic flip;
    longint x, y, z, dx, dy;
    t = ang + 32'h4000_0000;
    flip = t[31];
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'($signed(ang));
    x = longint'(uwjs_pkg::CORDIC_GAIN_Q30);
    y = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic jones_t predict_jones(beam_t b);
    longint ct, st, ch, sh, c2, s2, ne_t, delta, k, p, q;
    longint xr, xi, yr, yi;
    longint unsigned no, ne, cm, sm, root, m, qt, rm, lam;
    logic [31:0] frac, t32;
    jones_t r;
    no = 64'(cfg_no);
    ne = 64'(cfg_ne);
    lam = 64'(b.lam);
    xr = 64'(b.xr); xi = 64'(b.xi); yr = 64'(b.yr); yi = 64'(b.yi);
    rotate({cfg_tilt, 16'h0}, ct, st);
    ct = rnd_shift(ct, 15);
    st = rnd_shift(st, 15);
    cm = (ct < 0) ? -ct : ct;
    sm = (st < 0) ? -st : st;
    root = floor_sqrt(cm * cm * ne * ne + sm * sm * no * no);
    if (root == 0) ne_t = ((no > ne) ? no : ne) << 12;
    else ne_t = ((no * ne) << 27) / root;
    delta = ne_t - longint'(no << 12);
    frac = '0;
    if (lam != 0) begin
      m = ((delta < 0) ? -delta : delta) * longint'(b.thick);
      qt = m / lam;
      rm = m % lam;
      frac = {qt[23:0], 8'h0} | 32'((rm << 8) / lam);
      if (delta < 0) frac = 32'h0 - frac;
    end
    t32 = frac >> 1;
    rotate(t32, ch, sh);
    rotate({cfg_azim[14:0], 17'h0}, c2, s2);
    k = rnd_shift(ch, 30 - COEF);
    p = rnd_shift((sh * c2) >>> 30, 30 - COEF);
    q = rnd_shift((sh * s2) >>> 30, 30 - COEF);
    r.xr = clamp16(rnd_shift(k * xr + p * xi + q * yi, COEF));
    r.xi = clamp16(rnd_shift(k * xi - p * xr - q * yr, COEF));
    r.yr = clamp16(rnd_shift(q * xi + k * yr - p * yi, COEF));
    r.yi = clamp16(rnd_shift(k * yi + p * yr - q * xr, COEF));
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_vectors.push_back(predict_jones(cur_beam));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_beams.size() > 0) begin
          cur_beam <= pending_beams.pop_front();
          start <= 1'b1;
          gap_left <= no_gaps ? 0 : $urandom_range(0, 7);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    jones_t want;
    if (rst_n && out_valid) begin
      if (expected_vectors.size() == 0) begin
        $display("%0t: unexpected transaction, actual %0d %0d %0d %0d", $time,
                 out_x_real, out_x_imag, out_y_real, out_y_imag);
        failed = 1;
      end else begin
        want = expected_vectors.pop_front();
        if (want.xr !== out_x_real || want.xi !== out_x_imag ||
            want.yr !== out_y_real || want.yi !== out_y_imag) begin
          $display("%0t: mismatch, expected %0d %0d %0d %0d, actual %0d %0d %0d %0d", $time,
                   want.xr, want.xi, want.yr, want.yi,
                   out_x_real, out_x_imag, out_y_real, out_y_imag);
          failed = 1;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      uwjs_pkg::REG_ORD:  cfg_no = val[13:0];
      uwjs_pkg::REG_EXT:  cfg_ne = val[13:0];
      uwjs_pkg::REG_TILT: cfg_tilt = val[15:0];
      default:            cfg_azim = val[15:0];
    endcase
  endtask

  task automatic set_optics(int no, int ne, int tilt, int azim);
    write_reg(uwjs_pkg::REG_ORD, no);
    write_reg(uwjs_pkg::REG_EXT, ne);
    write_reg(uwjs_pkg::REG_TILT, tilt);
    write_reg(uwjs_pkg::REG_AZIM, azim);
  endtask

  task automatic add_beam(int lam, int thick, int xr, int xi, int yr, int yi);
    beam_t b;
    b.lam = 12'(lam); b.thick = 24'(thick);
    b.xr = 16'(xr); b.xi = 16'(xi); b.yr = 16'(yr); b.yi = 16'(yi);
    pending_beams.push_back(b);
  endtask

  task automatic add_random(int n);
    int lam, thick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
      lam = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(100, 4095);
      thick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom & 24'hFFFFFF;
      add_beam(lam, thick, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain();
    while (pending_beams.size() != 0 || start || expected_vectors.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    add_beam(550, 1000, 32767, 0, 0, 0);
    add_beam(0, 16777215, -32768, 32767, -32768, 32767);
    drain();
    set_optics(16383, 4096, 16384, 8192);
    add_beam(0, 12345, 1234, -4321, 777, -888);
    add_beam(100, 16777215, 32767, 32767, 32767, 32767);
    add_beam(4095, 16777215, -32768, -32768, -32768, -32768);
    add_beam(100, 0, -32768, 32767, 32767, -32768);
    add_beam(633, 2000, 23170, 0, 23170, 0);
    add_beam(4095, 1, 0, 0, 0, 0);
    add_beam(2048, 8388608, 32767, -32768, 0, 16384);
    drain();
    set_optics(4096, 16383, 65535, 65535);
    add_beam(100, 16777215, 32767, -32768, -32768, 32767);
    add_beam(4095, 777, 16384, 16384, -16384, -16384);
    add_beam(0, 100, 32767, 32767, 32767, 32767);
    add_random(100);
    drain();
    set_optics(6144, 0, 0, 8192);
    add_beam(500, 5000, 32767, 0, 0, 32767);
    add_random(40);
    drain();
    set_optics(0, 8000, 16384, 4096);
    add_beam(500, 5000, -32768, 0, 0, -32768);
    add_random(40);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_optics($urandom_range(0, 16383), $urandom_range(0, 16383),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      add_random(220);
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (failed || expected_vectors.size() != 0) begin
      $display("uniaxial_waveplate_jones_step verification failed");
    end else begin
      $display("uniaxial_waveplate_jones_step verification clean");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("uniaxial_waveplate_jones_step verification failed");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/uwjs_pkg.sv
rtl/core/uwjs_cordic.sv
rtl/core/uniaxial_waveplate_jones_step.sv
rtl/core/uwjs_checker.sv
sim/tb_uniaxial_waveplate_jones_step.sv
